[rtl/core/fbw_pkg.sv]
// Package for the fly-by-wire mode and rate controller.
// Holds the register map, mode codes, controller states and the structs between modules.
// No dependencies.
package fbw_pkg;

	// Field widths.
	localparam int SurfW  = 15;
	localparam int RateW  = 32;
	localparam int AltW   = 20;
	localparam int AccW   = 16;
	localparam int AddrW  = 5;

	// Flight mode codes.
	localparam logic [1:0] MODE_GROUND = 2'd0;
	localparam logic [1:0] MODE_NORMAL = 2'd1;
	localparam logic [1:0] MODE_FLARE  = 2'd2;
	localparam logic [1:0] MODE_RSVD   = 2'd3;

	// Register indexes.
	localparam logic [2:0] REG_PITCH_GAIN  = 3'd0;
	localparam logic [2:0] REG_BANK_GAIN   = 3'd1;
	localparam logic [2:0] REG_PITCH_STICK = 3'd2;
	localparam logic [2:0] REG_BANK_STICK  = 3'd3;
	localparam logic [2:0] REG_SURF_LIMIT  = 3'd4;
	localparam logic [2:0] REG_FLARE_ALT   = 3'd5;
	localparam logic [2:0] REG_LIFTOFF_DLY = 3'd6;
	localparam logic [2:0] REG_DEADBAND    = 3'd7;

	// Constants of the control law.
	localparam logic signed [15:0] MaxCmd         = 16'sd16383;
	localparam logic signed [15:0] FlareTrimStep  = 16'sd48;
	localparam logic signed [15:0] NormalTrimStep = 16'sd6;
	localparam logic signed [15:0] TrimElevThresh = 16'sd100;
	localparam logic [3:0]         FlareLastStep  = 4'd10;
	// Reciprocal of 1000 for a 29-bit dividend: ceil(2^39 / 1000).
	localparam logic [29:0]        Recip1000      = 30'd549755814;
	localparam int                 RecipShift     = 39;

	typedef struct packed {
		logic [15:0] pitch_gain;
		logic [15:0] bank_gain;
		logic [15:0] pitch_stick_rate;
		logic [15:0] bank_stick_rate;
		logic [14:0] surface_limit;
		logic [19:0] flare_altitude;
		logic [15:0] liftoff_delay_ms;
		logic [13:0] stick_deadband;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MODE,
		ST_DEM,
		ST_DIV,
		ST_SUM,
		ST_GAIN,
		ST_ACC,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic mode_upd;
		logic dem;
		logic div;
		logic sum;
		logic gain;
		logic acc;
		logic axis;     // 0 pitch, 1 roll
		logic out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

[rtl/core/fbw_if.sv]
// Item channel interfaces for the fly-by-wire controller.
// Depends on nothing; widths follow the field list of the block.
interface fbw_in_if;
	logic               valid;
	logic               ready;
	logic               toggle_enable;
	logic [19:0]        radio_altitude;
	logic               descending;
	logic               on_ground;
	logic [31:0]        now_ms;
	logic signed [31:0] pitch_rate;
	logic signed [31:0] roll_rate;
	logic signed [14:0] elevator_now;
	logic signed [14:0] aileron_now;
	logic signed [14:0] trim_now;
	logic signed [14:0] stick_x;
	logic signed [14:0] stick_y;

	modport source (output valid, toggle_enable, radio_altitude, descending, on_ground,
		now_ms, pitch_rate, roll_rate, elevator_now, aileron_now, trim_now, stick_x,
		stick_y, input ready);
	modport sink (input valid, toggle_enable, radio_altitude, descending, on_ground,
		now_ms, pitch_rate, roll_rate, elevator_now, aileron_now, trim_now, stick_x,
		stick_y, output ready);
endinterface

interface fbw_out_if;
	logic               valid;
	logic               ready;
	logic signed [14:0] elevator_cmd;
	logic signed [14:0] aileron_cmd;
	logic signed [14:0] trim_cmd;
	logic [2:0]         override_mask;
	logic [1:0]         mode;
	logic               mode_changed;

	modport source (output valid, elevator_cmd, aileron_cmd, trim_cmd, override_mask,
		mode, mode_changed, input ready);
	modport sink (input valid, elevator_cmd, aileron_cmd, trim_cmd, override_mask,
		mode, mode_changed, output ready);
endinterface

[rtl/core/fbw_regs.sv]
// APB-style configuration registers of the fly-by-wire controller.
// Depends on fbw_pkg for the register map and the configuration struct.
module fbw_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [fbw_pkg::AddrW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output fbw_pkg::cfg_t             cfg
);
	import fbw_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pitch_gain       <= 16'd10000;
			cfg_q.bank_gain        <= 16'd5000;
			cfg_q.pitch_stick_rate <= 16'd2294;
			cfg_q.bank_stick_rate  <= 16'd3277;
			cfg_q.surface_limit    <= 15'd16383;
			cfg_q.flare_altitude   <= 20'd880;
			cfg_q.liftoff_delay_ms <= 16'd3000;
			cfg_q.stick_deadband   <= 14'd20;
		end else if (wr_en) begin
			case (idx)
				REG_PITCH_GAIN:  cfg_q.pitch_gain       <= pwdata[15:0];
				REG_BANK_GAIN:   cfg_q.bank_gain        <= pwdata[15:0];
				REG_PITCH_STICK: cfg_q.pitch_stick_rate <= pwdata[15:0];
				REG_BANK_STICK:  cfg_q.bank_stick_rate  <= pwdata[15:0];
				REG_SURF_LIMIT:  cfg_q.surface_limit    <= pwdata[14:0];
				REG_FLARE_ALT:   cfg_q.flare_altitude   <= pwdata[19:0];
				REG_LIFTOFF_DLY: cfg_q.liftoff_delay_ms <= pwdata[15:0];
				REG_DEADBAND:    cfg_q.stick_deadband   <= pwdata[13:0];
				default: ;
			endcase
		end
	end

	// Read-back multiplexer.
	always_comb begin
		case (idx)
			REG_PITCH_GAIN:  prdata = {16'd0, cfg_q.pitch_gain};
			REG_BANK_GAIN:   prdata = {16'd0, cfg_q.bank_gain};
			REG_PITCH_STICK: prdata = {16'd0, cfg_q.pitch_stick_rate};
			REG_BANK_STICK:  prdata = {16'd0, cfg_q.bank_stick_rate};
			REG_SURF_LIMIT:  prdata = {17'd0, cfg_q.surface_limit};
			REG_FLARE_ALT:   prdata = {12'd0, cfg_q.flare_altitude};
			REG_LIFTOFF_DLY: prdata = {16'd0, cfg_q.liftoff_delay_ms};
			REG_DEADBAND:    prdata = {18'd0, cfg_q.stick_deadband};
			default:         prdata = 32'd0;
		endcase
	end
endmodule

[rtl/core/fbw_ctrl.sv]
// Sequencer of the fly-by-wire controller: steps one item through the datapath.
// Depends on fbw_pkg for the state type and the command and status structs.
module fbw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fbw_pkg::dp_stat_t stat,
	output fbw_pkg::dp_cmd_t  cmd
);
	import fbw_pkg::*;

	state_t state_q, state_d;
	logic   axis_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_MODE;
			ST_MODE: state_d = ST_DEM;
			ST_DEM:  state_d = ST_DIV;
			ST_DIV:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_GAIN;
			ST_GAIN: state_d = ST_ACC;
			ST_ACC:  state_d = axis_q ? ST_OUT : ST_DEM;
			ST_OUT:  if (stat.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		cmd          = '0;
		cmd.axis     = axis_q;
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.mode_upd = (state_q == ST_MODE);
		cmd.dem      = (state_q == ST_DEM);
		cmd.div      = (state_q == ST_DIV);
		cmd.sum      = (state_q == ST_SUM);
		cmd.gain     = (state_q == ST_GAIN);
		cmd.acc      = (state_q == ST_ACC);
		cmd.out_load = (state_q == ST_OUT) && stat.out_free;
	end

	// State and axis select: pitch first, then roll.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MODE) begin
				axis_q <= 1'b0;
			end else if (state_q == ST_ACC) begin
				axis_q <= ~axis_q;
			end
		end
	end

	// The axis only changes at the end of an axis pass.
	a_axis_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_SUM || state_q == ST_GAIN) |-> $stable(axis_q))
		else $error("axis changed inside an axis pass");
	// A result leaves only after the roll pass.
	a_out_after_roll: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> $past(state_q == ST_OUT) || $past(axis_q))
		else $error("result before roll pass");
	// An item is taken only in idle.
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_MODE))
		else $error("capture did not start an item");
endmodule

[rtl/core/fbw_dp.sv]
// Datapath of the fly-by-wire controller: mode logic, trim and the shared rate-law unit.
// Depends on fbw_pkg and the item interfaces; driven by fbw_ctrl.
module fbw_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  fbw_pkg::cfg_t     cfg,
	input  fbw_pkg::dp_cmd_t  cmd,
	output fbw_pkg::dp_stat_t stat,
	fbw_in_if.sink            in_ch,
	fbw_out_if.source         out_ch
);
	import fbw_pkg::*;

	// Captured item.
	logic               tog_q, desc_q, gnd_q;
	logic [19:0]        ra_q;
	logic [31:0]        now_q;
	logic signed [31:0] prate_q, rrate_q;
	logic signed [14:0] elev_q, ail_q, trim_q, sx_q, sy_q;

	// Block state.
	logic               enabled_q, inhibit_q, ploaded_q, rloaded_q, run_q;
	logic [1:0]         mode_q;
	logic [31:0]        liftoff_q;
	logic [3:0]         fstep_q;
	logic [2:0]         ovr_q;
	logic signed [15:0] pacc_q, racc_q;

	// Working results.
	logic signed [14:0] elev_cmd_q, ail_cmd_q, trim_cmd_q;
	logic               chg_q;

	// Output register.
	logic               out_valid_q;
	logic signed [14:0] o_elev_q, o_ail_q, o_trim_q;
	logic [2:0]         o_ovr_q;
	logic [1:0]         o_mode_q;
	logic               o_chg_q;

	// Pipeline of the rate law.
	logic               neg_s1, neg_s2;
	logic [28:0]        mag_s1;
	logic [19:0]        q_s2;
	logic signed [32:0] x_s3;
	logic signed [49:0] gp_s4;

	logic signed [15:0] lim;
	assign lim = ({1'b0, cfg.surface_limit} > MaxCmd) ? MaxCmd
		: $signed({1'b0, cfg.surface_limit});

	// Mode update, trim adjustment and clears for one item.
	logic               m_en, m_pl, m_rl, m_inh, m_chg;
	logic [1:0]         m_old, m_mode;
	logic [31:0]        m_lt;
	logic [3:0]         m_fs;
	logic [2:0]         m_ovr;
	logic signed [15:0] m_trim, trim16, t_adj;
	logic [31:0]        elapsed;

	always_comb begin
		m_en   = enabled_q;
		m_old  = mode_q;
		m_pl   = ploaded_q;
		m_rl   = rloaded_q;
		m_ovr  = ovr_q;
		m_inh  = inhibit_q;
		m_lt   = liftoff_q;
		m_fs   = fstep_q;
		trim16 = 16'(trim_q);
		m_trim = trim16;
		t_adj  = trim16;
		if (tog_q) begin
			if (enabled_q) begin
				m_en  = 1'b0;
				m_old = MODE_GROUND;
				m_pl  = 1'b0;
				m_rl  = 1'b0;
				m_ovr = 3'd0;
			end else begin
				m_en = 1'b1;
			end
		end
		m_mode = m_old;
		if (ra_q > cfg.flare_altitude) begin
			if (m_old != MODE_GROUND) m_mode = MODE_NORMAL;
		end else if (!inhibit_q && desc_q) begin
			m_mode = MODE_FLARE;
		end
		if (gnd_q) m_mode = MODE_GROUND;
		elapsed = now_q - liftoff_q;
		if (m_mode == MODE_GROUND) begin
			m_inh = 1'b1;
			if (gnd_q) begin
				m_lt = now_q;
			end else if (elapsed > {16'd0, cfg.liftoff_delay_ms}) begin
				m_mode = MODE_NORMAL;
			end
		end else if (m_mode == MODE_NORMAL) begin
			m_inh = 1'b0;
		end
		m_chg = m_en && (m_mode != m_old);
		if (m_en) begin
			case (m_mode)
				MODE_GROUND: begin
					m_pl  = 1'b0;
					m_rl  = 1'b0;
					m_ovr = 3'd0;
					m_fs  = 4'd0;
				end
				MODE_FLARE: begin
					m_pl  = 1'b0;
					m_rl  = 1'b0;
					m_ovr = 3'd4;
					if (fstep_q <= FlareLastStep) begin
						if (!fstep_q[0]) begin
							t_adj  = trim16 - FlareTrimStep;
							m_trim = (t_adj > lim) ? lim : ((t_adj < -lim) ? -lim : t_adj);
						end
						m_fs = fstep_q + 4'd1;
					end
				end
				default: begin
					m_ovr = 3'd7;
					m_fs  = 4'd0;
					if (16'(elev_q) > TrimElevThresh) begin
						t_adj  = trim16 + NormalTrimStep;
						m_trim = (t_adj > lim) ? lim : ((t_adj < -lim) ? -lim : t_adj);
					end else if (16'(elev_q) < -TrimElevThresh) begin
						t_adj  = trim16 - NormalTrimStep;
						m_trim = (t_adj > lim) ? lim : ((t_adj < -lim) ? -lim : t_adj);
					end
				end
			endcase
		end
	end

	// Stick demand: scale times half stick, with the deadband.
	logic signed [14:0] st;
	logic signed [15:0] st16, half16, smag;
	logic signed [13:0] half14;
	logic signed [30:0] dprod, dabs;
	logic [15:0]        scale;
	always_comb begin
		st     = cmd.axis ? sx_q : sy_q;
		scale  = cmd.axis ? cfg.bank_stick_rate : cfg.pitch_stick_rate;
		st16   = 16'(st);
		half16 = (st16 + {15'd0, st[14]}) >>> 1;
		half14 = half16[13:0];
		smag   = st[14] ? -st16 : st16;
		dprod  = $signed({1'b0, scale}) * half14;
		dabs   = dprod[30] ? -dprod : dprod;
	end

	// Division by 1000 through the reciprocal.
	logic [58:0] qprod;
	assign qprod = 59'(mag_s1) * 59'(Recip1000);

	// Demand plus body rate.
	logic signed [20:0] dem;
	logic signed [31:0] rate;
	assign dem  = neg_s2 ? -$signed({1'b0, q_s2}) : $signed({1'b0, q_s2});
	assign rate = cmd.axis ? rrate_q : prate_q;

	// Gain product.
	logic [15:0] gain;
	assign gain = cmd.axis ? cfg.bank_gain : cfg.pitch_gain;

	// Step truncation, saturation and accumulator clamp.
	logic signed [49:0] gadj;
	logic signed [33:0] stp_w;
	logic signed [15:0] stp, acc, sum_c;
	logic signed [16:0] sum17;
	logic signed [14:0] pos;
	logic               loaded;
	always_comb begin
		gadj   = gp_s4 + (gp_s4[49] ? 50'sd65535 : 50'sd0);
		stp_w  = gadj[49:16];
		stp    = (stp_w > 34'sd32767) ? 16'sh7FFF
			: ((stp_w < -34'sd32768) ? 16'sh8000 : stp_w[15:0]);
		acc    = cmd.axis ? racc_q : pacc_q;
		pos    = cmd.axis ? ail_q : elev_q;
		loaded = cmd.axis ? rloaded_q : ploaded_q;
		sum17  = 17'(acc) + 17'(stp);
		sum_c  = (sum17 > 17'(lim)) ? lim
			: ((sum17 < -17'(lim)) ? -lim : sum17[15:0]);
	end

	// Item capture and pipeline registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tog_q   <= in_ch.toggle_enable;
			ra_q    <= in_ch.radio_altitude;
			desc_q  <= in_ch.descending;
			gnd_q   <= in_ch.on_ground;
			now_q   <= in_ch.now_ms;
			prate_q <= in_ch.pitch_rate;
			rrate_q <= in_ch.roll_rate;
			elev_q  <= in_ch.elevator_now;
			ail_q   <= in_ch.aileron_now;
			trim_q  <= in_ch.trim_now;
			sx_q    <= in_ch.stick_x;
			sy_q    <= in_ch.stick_y;
		end
		if (cmd.dem) begin
			neg_s1 <= dprod[30];
			mag_s1 <= (smag < $signed({2'b0, cfg.stick_deadband})) ? 29'd0 : dabs[28:0];
		end
		if (cmd.div) begin
			neg_s2 <= neg_s1;
			q_s2   <= qprod[RecipShift +: 20];
		end
		if (cmd.sum) x_s3 <= 33'(rate) + 33'(dem);
		if (cmd.gain) gp_s4 <= x_s3 * $signed({1'b0, gain});
		if (cmd.mode_upd) begin
			elev_cmd_q <= elev_q;
			ail_cmd_q  <= ail_q;
			trim_cmd_q <= m_trim[14:0];
			chg_q      <= m_chg;
		end
		if (cmd.acc && run_q) begin
			if (cmd.axis) ail_cmd_q <= loaded ? sum_c[14:0] : pos;
			else          elev_cmd_q <= loaded ? sum_c[14:0] : pos;
		end
		if (cmd.out_load) begin
			o_elev_q <= elev_cmd_q;
			o_ail_q  <= ail_cmd_q;
			o_trim_q <= trim_cmd_q;
			o_ovr_q  <= ovr_q;
			o_mode_q <= mode_q;
			o_chg_q  <= chg_q;
		end
	end

	// Block state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q   <= 1'b0;
			mode_q      <= MODE_GROUND;
			inhibit_q   <= 1'b1;
			liftoff_q   <= 32'd0;
			fstep_q     <= 4'd0;
			pacc_q      <= 16'sd0;
			racc_q      <= 16'sd0;
			ploaded_q   <= 1'b0;
			rloaded_q   <= 1'b0;
			ovr_q       <= 3'd0;
			run_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.mode_upd) begin
				enabled_q <= m_en;
				mode_q    <= m_mode;
				inhibit_q <= m_inh;
				liftoff_q <= m_lt;
				fstep_q   <= m_fs;
				ploaded_q <= m_pl;
				rloaded_q <= m_rl;
				ovr_q     <= m_ovr;
				run_q     <= m_en && (m_mode == MODE_NORMAL);
			end
			if (cmd.acc && run_q) begin
				if (cmd.axis) begin
					rloaded_q <= 1'b1;
					racc_q    <= loaded ? sum_c : 16'(pos);
				end else begin
					ploaded_q <= 1'b1;
					pacc_q    <= loaded ? sum_c : 16'(pos);
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_free      = !out_valid_q || out_ch.ready;
	assign in_ch.ready        = cmd.capture || (!in_ch.valid && cmd.out_load) ? 1'b1 : 1'b0;
	assign out_ch.valid       = out_valid_q;
	assign out_ch.elevator_cmd  = o_elev_q;
	assign out_ch.aileron_cmd   = o_ail_q;
	assign out_ch.trim_cmd      = o_trim_q;
	assign out_ch.override_mask = o_ovr_q;
	assign out_ch.mode          = o_mode_q;
	assign out_ch.mode_changed  = o_chg_q;

	// The flare trim counter stops one past its last step.
	a_fstep: assert property (@(posedge clk) disable iff (!arst_n) fstep_q <= 4'd11)
		else $error("flare step counter overran");
	// Enabled on the ground means no controller holds a position.
	a_ground_unloaded: assert property (@(posedge clk) disable iff (!arst_n)
		(enabled_q && mode_q == MODE_GROUND) |-> (!ploaded_q && !rloaded_q))
		else $error("controller loaded in ground mode");
	// The reserved mode code never appears.
	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n) mode_q != MODE_RSVD)
		else $error("reserved mode code");
endmodule

[rtl/core/fly_by_wire_mode_rate_controller.sv]
// Fly-by-wire mode and rate controller, top level.
// The sequencer steps each accepted item through the mode update, then both axes in turn
// through one shared demand, reciprocal-divide and gain multiplier chain, and loads
// its result into the output register; it takes a new item only in idle, after that load.
// The output register lets the next item be taken while a result waits.
// Reset (arst_n, asynchronous) clears mode state, controllers and restores register defaults.
module fly_by_wire_mode_rate_controller (
	input  logic                      clk,
	input  logic                      arst_n,
	fbw_in_if.sink                    in_ch,
	fbw_out_if.source                 out_ch,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [fbw_pkg::AddrW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import fbw_pkg::*;

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     ctrl_ready;

	// Configuration registers.
	fbw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer.
	fbw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (ctrl_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath; it drives the ready of the input channel from the capture and output-load commands.
	fbw_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.stat   (stat),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// An item offered in idle is always taken, whatever the datapath does.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_ready && in_ch.valid) |-> in_ch.ready)
		else $error("item offered in idle but not taken");
endmodule

[bench/fly_by_wire_mode_rate_controller_tb.sv]
// Testbench for the fly-by-wire mode and rate controller.
// Drives flight frames through the item channels, predicts every command and checks it.
// Depends on fbw_pkg, fbw_if and the fly_by_wire_mode_rate_controller RTL.
module fly_by_wire_mode_rate_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fbw_pkg::*;

	localparam int CycleLimit  = 400000;
	localparam int ItemsPerSet = 80;
	localparam int DrainCycles = 30;

	typedef struct packed {
		logic               toggle_enable;
		logic [19:0]        radio_altitude;
		logic               descending;
		logic               on_ground;
		logic [31:0]        now_ms;
		logic signed [31:0] pitch_rate;
		logic signed [31:0] roll_rate;
		logic signed [14:0] elevator_now;
		logic signed [14:0] aileron_now;
		logic signed [14:0] trim_now;
		logic signed [14:0] stick_x;
		logic signed [14:0] stick_y;
	} frame_t;

	typedef struct packed {
		logic signed [14:0] elevator_cmd;
		logic signed [14:0] aileron_cmd;
		logic signed [14:0] trim_cmd;
		logic [2:0]         override_mask;
		logic [1:0]         mode;
		logic               mode_changed;
	} command_t;

	typedef struct packed {
		frame_t   frame;
		logic     typed;
		command_t want;
	} frame_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [AddrW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	fbw_in_if  in_ch();
	fbw_out_if out_ch();

	fly_by_wire_mode_rate_controller dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Clock, 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow of the block's registers and state.
	cfg_t        cfg;
	logic        fl_enabled;
	logic [1:0]  fl_mode;
	logic        fl_inhibit;
	logic [31:0] fl_liftoff;
	logic [3:0]  fl_flare_step;
	shortint     pitch_acc, roll_acc;
	bit          pitch_ld, roll_ld;
	logic [2:0]  fl_override;

	command_t expected_cmds[$];
	int errors = 0;
	int frames_sent = 0;
	int cmds_seen = 0;
	int cycles = 0;
	bit held_once = 0;

	function automatic longint clampl(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint surf_lim();
		return (cfg.surface_limit > 15'd16383) ? 16383 : longint'(cfg.surface_limit);
	endfunction

	// One incremental rate controller: load on first use, then integrate the rate error.
	function automatic logic signed [14:0] rate_axis(input longint stick, input longint rate,
			input longint pos, input logic [15:0] scale, input logic [15:0] gain,
			inout shortint acc, inout bit loaded);
		longint lim, mag, demand, stepv, total;
		lim = surf_lim();
		mag = stick < 0 ? -stick : stick;
		demand = 0;
		if (!loaded) begin
			loaded = 1;
			acc = shortint'(pos);
			return pos[14:0];
		end
		if (mag >= longint'(cfg.stick_deadband))
			demand = (longint'(scale) * (stick / 2)) / 1000;
		stepv = clampl(((demand + rate) * longint'(gain)) / 65536, -32768, 32767);
		total = clampl(longint'(acc) + stepv, -lim, lim);
		acc = shortint'(total);
		return total[14:0];
	endfunction

	// Works out the command for one frame and advances the shadow state.
	function automatic command_t predict_frame(frame_t f);
		command_t c;
		logic [1:0] old_mode;
		logic [31:0] dt;
		longint lim, trim;
		lim = surf_lim();
		trim = longint'(f.trim_now);
		c.elevator_cmd = f.elevator_now;
		c.aileron_cmd = f.aileron_now;
		c.trim_cmd = f.trim_now;
		if (f.toggle_enable) begin
			if (fl_enabled) begin
				fl_enabled = 0;
				fl_mode = MODE_GROUND;
				pitch_ld = 0;
				roll_ld = 0;
				fl_override = 3'd0;
			end else begin
				fl_enabled = 1;
			end
		end
		// Mode update runs whether or not the block is enabled.
		old_mode = fl_mode;
		if (f.radio_altitude > cfg.flare_altitude) begin
			if (fl_mode != MODE_GROUND)
				fl_mode = MODE_NORMAL;
		end else if (!fl_inhibit && f.descending) begin
			fl_mode = MODE_FLARE;
		end
		if (f.on_ground)
			fl_mode = MODE_GROUND;
		if (fl_mode == MODE_GROUND) begin
			fl_inhibit = 1;
			dt = f.now_ms - fl_liftoff;
			if (f.on_ground)
				fl_liftoff = f.now_ms;
			else if (dt > {16'd0, cfg.liftoff_delay_ms})
				fl_mode = MODE_NORMAL;
		end else if (fl_mode == MODE_NORMAL) begin
			fl_inhibit = 0;
		end
		if (fl_enabled) begin
			if (fl_mode == MODE_GROUND) begin
				pitch_ld = 0;
				roll_ld = 0;
				fl_override = 3'd0;
				fl_flare_step = 4'd0;
			end else if (fl_mode == MODE_FLARE) begin
				pitch_ld = 0;
				roll_ld = 0;
				fl_override = 3'd4;
				if (fl_flare_step <= 4'd10) begin
					if (!fl_flare_step[0])
						c.trim_cmd = 15'(clampl(trim - 48, -lim, lim));
					fl_flare_step = fl_flare_step + 4'd1;
				end
			end else begin
				fl_override = 3'd7;
				fl_flare_step = 4'd0;
				if (f.elevator_now > 15'sd100)
					c.trim_cmd = 15'(clampl(trim + 6, -lim, lim));
				else if (f.elevator_now < -15'sd100)
					c.trim_cmd = 15'(clampl(trim - 6, -lim, lim));
				c.elevator_cmd = rate_axis(f.stick_y, f.pitch_rate, f.elevator_now,
					cfg.pitch_stick_rate, cfg.pitch_gain, pitch_acc, pitch_ld);
				c.aileron_cmd = rate_axis(f.stick_x, f.roll_rate, f.aileron_now,
					cfg.bank_stick_rate, cfg.bank_gain, roll_acc, roll_ld);
			end
		end
		c.override_mask = fl_override;
		c.mode = fl_mode;
		c.mode_changed = fl_enabled && (fl_mode != old_mode);
		return c;
	endfunction

	// Builds a frame from plain integers, cutting each to its field width.
	function automatic frame_t mk_frame(int tog, int alt, int desc, int gnd,
			longint now, longint pr, longint rr,
			int el, int ai, int tr, int sx, int sy);
		frame_t f;
		f.toggle_enable = 1'(tog);
		f.radio_altitude = 20'(alt);
		f.descending = 1'(desc);
		f.on_ground = 1'(gnd);
		f.now_ms = 32'(now);
		f.pitch_rate = 32'(pr);
		f.roll_rate = 32'(rr);
		f.elevator_now = 15'(el);
		f.aileron_now = 15'(ai);
		f.trim_now = 15'(tr);
		f.stick_x = 15'(sx);
		f.stick_y = 15'(sy);
		return f;
	endfunction

	function automatic logic signed [14:0] rnd_surface();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 15'sd16383;
		if (r == 1)
			return -15'sd16383;
		return 15'(int'($urandom_range(0, 32766)) - 16383);
	endfunction

	// Sends one item and records its expected command once it is accepted.
	task automatic send_frame(frame_t f, logic typed, command_t want);
		command_t c;
		int r, gap;
		in_ch.toggle_enable <= f.toggle_enable;
		in_ch.radio_altitude <= f.radio_altitude;
		in_ch.descending <= f.descending;
		in_ch.on_ground <= f.on_ground;
		in_ch.now_ms <= f.now_ms;
		in_ch.pitch_rate <= f.pitch_rate;
		in_ch.roll_rate <= f.roll_rate;
		in_ch.elevator_now <= f.elevator_now;
		in_ch.aileron_now <= f.aileron_now;
		in_ch.trim_now <= f.trim_now;
		in_ch.stick_x <= f.stick_x;
		in_ch.stick_y <= f.stick_y;
		in_ch.valid <= 1'b1;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		c = predict_frame(f);
		expected_cmds.push_back(typed ? want : c);
		frames_sent++;
		@(negedge clk);
		r = $urandom_range(0, 99);
		gap = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Register write followed by a read-back, both from a falling edge.
	task automatic reg_write(logic [2:0] idx, logic [31:0] val, logic [31:0] mask);
		paddr <= AddrW'({idx, 2'b00});
		pwdata <= val;
		pwrite <= 1'b1;
		psel <= 1'b1;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if ((prdata & mask) !== (val & mask)) begin
			$display("%0t register %0d read back: expected %h actual %h",
				$time, idx, val & mask, prdata & mask);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_cfg(cfg_t c);
		reg_write(REG_PITCH_GAIN, 32'(c.pitch_gain), 32'hFFFF);
		reg_write(REG_BANK_GAIN, 32'(c.bank_gain), 32'hFFFF);
		reg_write(REG_PITCH_STICK, 32'(c.pitch_stick_rate), 32'hFFFF);
		reg_write(REG_BANK_STICK, 32'(c.bank_stick_rate), 32'hFFFF);
		reg_write(REG_SURF_LIMIT, 32'(c.surface_limit), 32'h7FFF);
		reg_write(REG_FLARE_ALT, 32'(c.flare_altitude), 32'hFFFFF);
		reg_write(REG_LIFTOFF_DLY, 32'(c.liftoff_delay_ms), 32'hFFFF);
		reg_write(REG_DEADBAND, 32'(c.stick_deadband), 32'h3FFF);
		cfg = c;
	endtask

	task automatic drain();
		while (expected_cmds.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	// Receiver: random ready with one long hold-off so the block backs up.
	initial begin
		int r, n, k;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_once && frames_sent >= 150) begin
				out_ch.ready <= 1'b0;
				k = 0;
				while (k < 300) begin
					@(negedge clk);
					k++;
				end
				held_once = 1;
			end
			r = $urandom_range(0, 99);
			if (r < 60) begin
				out_ch.ready <= 1'b1;
				n = $urandom_range(1, 20);
			end else begin
				out_ch.ready <= 1'b0;
				n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
			end
			repeat (n - 1) @(negedge clk);
		end
	end

	// Compares each command with the oldest expectation.
	always @(posedge clk) begin
		command_t w;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			cmds_seen++;
			if (expected_cmds.size() == 0) begin
				$display("%0t command with none expected: actual %h", $time,
					{out_ch.elevator_cmd, out_ch.aileron_cmd, out_ch.trim_cmd,
					out_ch.override_mask, out_ch.mode, out_ch.mode_changed});
				errors++;
			end else begin
				w = expected_cmds.pop_front();
				if (out_ch.elevator_cmd !== w.elevator_cmd) begin
					$display("%0t elevator_cmd: expected %0d actual %0d", $time,
						w.elevator_cmd, out_ch.elevator_cmd);
					errors++;
				end
				if (out_ch.aileron_cmd !== w.aileron_cmd) begin
					$display("%0t aileron_cmd: expected %0d actual %0d", $time,
						w.aileron_cmd, out_ch.aileron_cmd);
					errors++;
				end
				if (out_ch.trim_cmd !== w.trim_cmd) begin
					$display("%0t trim_cmd: expected %0d actual %0d", $time,
						w.trim_cmd, out_ch.trim_cmd);
					errors++;
				end
				if (out_ch.override_mask !== w.override_mask) begin
					$display("%0t override_mask: expected %0d actual %0d", $time,
						w.override_mask, out_ch.override_mask);
					errors++;
				end
				if (out_ch.mode !== w.mode) begin
					$display("%0t mode: expected %0d actual %0d", $time,
						w.mode, out_ch.mode);
					errors++;
				end
				if (out_ch.mode_changed !== w.mode_changed) begin
					$display("%0t mode_changed: expected %0d actual %0d", $time,
						w.mode_changed, out_ch.mode_changed);
					errors++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("fly_by_wire_mode_rate_controller_tb failed");
			$finish;
		end
	end

	// Stimulus.
	initial begin
		frame_row_t rows[$];
		cfg_t sets[$];
		cfg_t c;
		frame_t f;
		command_t none;
		logic [31:0] sim_now;
		int i, s, ph, r;

		in_ch.valid = 1'b0;
		in_ch.toggle_enable = 1'b0;
		in_ch.radio_altitude = '0;
		in_ch.descending = 1'b0;
		in_ch.on_ground = 1'b0;
		in_ch.now_ms = '0;
		in_ch.pitch_rate = '0;
		in_ch.roll_rate = '0;
		in_ch.elevator_now = '0;
		in_ch.aileron_now = '0;
		in_ch.trim_now = '0;
		in_ch.stick_x = '0;
		in_ch.stick_y = '0;
		none = '0;

		cfg = '{16'd10000, 16'd5000, 16'd2294, 16'd3277, 15'd16383, 20'd880,
			16'd3000, 14'd20};
		fl_enabled = 0;
		fl_mode = MODE_GROUND;
		fl_inhibit = 1;
		fl_liftoff = '0;
		fl_flare_step = '0;
		pitch_acc = 0;
		roll_acc = 0;
		pitch_ld = 0;
		roll_ld = 0;
		fl_override = '0;

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed frames under the reset settings: disabled pass-through, enable,
		// liftoff, the rate law at its extremes, flare steps, go-around, touchdown,
		// disable, and a liftoff timer that straddles the wrap of the clock.
		rows.push_back('{mk_frame(0, 0, 0, 1, 100, 0, 0, 16383, -16383, 0, 0, 0), 1,
			'{15'sd16383, -15'sd16383, 15'sd0, 3'd0, MODE_GROUND, 1'b0}});
		rows.push_back('{mk_frame(1, 0, 0, 1, 200, 0, 0, -16383, 16383, 16383, 0, 0), 1,
			'{-15'sd16383, 15'sd16383, 15'sd16383, 3'd0, MODE_GROUND, 1'b0}});
		rows.push_back('{mk_frame(0, 20'hFFFFF, 0, 0, 300, 0, 0, 5, 5, 5, 0, 0), 0, none});
		rows.push_back('{mk_frame(0, 20'hFFFFF, 0, 0, 3500, 0, 0, 200, -300, 16383, 0, 0),
			0, none});
		rows.push_back('{mk_frame(0, 20'hFFFFF, 0, 0, 3520, 32'h7FFFFFFF, 32'h80000000,
			16383, -16383, 16383, 16383, -16383), 0, none});
		rows.push_back('{mk_frame(0, 20'hFFFFF, 0, 0, 3540, 32'h80000000, 32'h7FFFFFFF,
			-16383, 16383, -16383, -16383, 16383), 0, none});
		rows.push_back('{mk_frame(0, 20'hFFFFF, 0, 0, 3560, 32'h00010000, -32'sh00010000,
			101, -101, 0, 19, -19), 0, none});
		rows.push_back('{mk_frame(0, 20'hFFFFF, 0, 0, 3580, 0, 0, 100, -100, 0, 20, -20),
			0, none});
		rows.push_back('{mk_frame(0, 880, 1, 0, 3600, 0, 0, 0, 0, -16383, 0, 0), 0, none});
		for (i = 0; i < 12; i++)
			rows.push_back('{mk_frame(0, 0, 1, 0, 3620 + i, 0, 0, 0, 0, -16300, 0, 0),
				0, none});
		rows.push_back('{mk_frame(0, 881, 0, 0, 3700, 0, 0, 7, 7, 7, 3, 3), 0, none});
		rows.push_back('{mk_frame(0, 0, 0, 1, 32'hFFFFFF00, 0, 0, 1, 1, 1, 0, 0), 0, none});
		rows.push_back('{mk_frame(0, 20'hFFFFF, 0, 0, 32'h00000B00, 0, 0, 1, 1, 1, 0, 0),
			0, none});
		rows.push_back('{mk_frame(1, 20'hFFFFF, 0, 0, 32'h00000C00, 0, 0, 9, 9, 9, 0, 0),
			0, none});
		rows.push_back('{mk_frame(1, 20'hFFFFF, 0, 0, 32'h00000D00, 0, 0, 9, 9, 9, 0, 0),
			0, none});
		foreach (rows[k])
			send_frame(rows[k].frame, rows[k].typed, rows[k].want);
		in_ch.valid <= 1'b0;
		drain();

		// Register settings: defaults, both extremes, and random middles.
		sets.push_back('{16'd10000, 16'd5000, 16'd2294, 16'd3277, 15'd16383, 20'd880,
			16'd3000, 14'd20});
		sets.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 20'hFFFFF,
			16'hFFFF, 14'h3FFF});
		sets.push_back('{16'd0, 16'd0, 16'd0, 16'd0, 15'd0, 20'd0, 16'd0, 14'd0});
		for (i = 0; i < 2; i++) begin
			c.pitch_gain = 16'($urandom);
			c.bank_gain = 16'($urandom);
			c.pitch_stick_rate = 16'($urandom);
			c.bank_stick_rate = 16'($urandom);
			c.surface_limit = 15'($urandom_range(100, 32767));
			c.flare_altitude = 20'($urandom_range(0, 4000));
			c.liftoff_delay_ms = 16'($urandom_range(0, 5000));
			c.stick_deadband = 14'($urandom_range(0, 2000));
			sets.push_back(c);
		end

		// Random flights: ground roll, climb, cruise, approach and touchdown, with
		// the odd toggle and some frames of pure noise.
		sim_now = $urandom;
		for (s = 0; s < sets.size(); s++) begin
			load_cfg(sets[s]);
			@(negedge clk);
			for (i = 0; i < ItemsPerSet; i++) begin
				ph = i % 40;
				r = $urandom_range(0, 99);
				sim_now = sim_now + $urandom_range(1, 900);
				f.toggle_enable = ($urandom_range(0, 99) < 3);
				f.now_ms = sim_now;
				f.pitch_rate = ($urandom_range(0, 3) == 0) ? $urandom
					: 32'(int'($urandom_range(0, 262144)) - 131072);
				f.roll_rate = ($urandom_range(0, 3) == 0) ? $urandom
					: 32'(int'($urandom_range(0, 262144)) - 131072);
				f.elevator_now = rnd_surface();
				f.aileron_now = rnd_surface();
				f.trim_now = rnd_surface();
				f.stick_x = ($urandom_range(0, 4) == 0) ? 15'($urandom_range(0, 40) - 20)
					: rnd_surface();
				f.stick_y = ($urandom_range(0, 4) == 0) ? 15'($urandom_range(0, 40) - 20)
					: rnd_surface();
				if (r < 10) begin
					f.toggle_enable = 1'($urandom);
					f.radio_altitude = 20'($urandom);
					f.descending = 1'($urandom);
					f.on_ground = 1'($urandom);
					f.now_ms = $urandom;
				end else if (ph < 5 || ph >= 35) begin
					f.radio_altitude = 20'($urandom_range(0, 200));
					f.descending = 1'($urandom);
					f.on_ground = 1'b1;
				end else if (ph < 25) begin
					f.radio_altitude = (cfg.flare_altitude == 20'hFFFFF) ? 20'hFFFFF
						: 20'($urandom_range(int'(cfg.flare_altitude) + 1, 20'hFFFFF));
					f.descending = ($urandom_range(0, 3) == 0);
					f.on_ground = 1'b0;
				end else begin
					f.radio_altitude = 20'($urandom_range(0, int'(cfg.flare_altitude)));
					f.descending = ($urandom_range(0, 9) != 0);
					f.on_ground = 1'b0;
				end
				send_frame(f, 1'b0, none);
			end
			in_ch.valid <= 1'b0;
			drain();
		end

		$display("Sent %0d frames over %0d register settings; %0d commands checked.",
			frames_sent, sets.size() + 1, cmds_seen);
		$display("Covered ground, normal and flare modes, toggles, clamps and a long output stall.");
		if (errors == 0 && expected_cmds.size() == 0)
			$display("fly_by_wire_mode_rate_controller_tb passed");
		else
			$display("fly_by_wire_mode_rate_controller_tb failed");
		$finish;
	end

endmodule
